/* sv/lru_page_replacement_defines.svh */
// assertion macros shared by the lru page replacement design
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define LPR_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define LPR_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lpr_pkg.sv */
// types and constants of the lru page replacement block
package lpr_pkg;

  // field widths of the request, the response and the apb register interface
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // request actions
  localparam logic ACT_REFERENCE = 1'b0;
  localparam logic ACT_CLEAR     = 1'b1;

  // register map
  localparam logic REG_SEL_WAYS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = 8'd128;

  // saturation value of the hit counter
  localparam logic [COUNT_W-1:0] HIT_COUNT_MAX = '1;

  // entries per group of the hit priority encoder
  localparam int unsigned GRP_SIZE = 16;
  localparam int unsigned GRP_IDX_W = 4;

  typedef struct packed {
    logic              action;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [POS_W-1:0]   hit_position;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] hit_count;
  } rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cap;
    logic cmp;
    logic enc;
    logic sel;
    logic upd;
  } cmd_t;

endpackage

/* sv/lpr_stream_if.sv */
// valid/ready stream channel carrying one payload per request
interface lpr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/lru_page_replacement.sv */
// lru page replacement: each request passes the steps capture, compare, group encode,
// select and update before the next one is taken; the response is registered at the update
// the next request can be taken in the cycle after the update
// a held response does not block taking the next request, only its update step
// reset is asynchronous: stack empty, hit count zero, ways_in_use 128
// stored page values are not reset; only entries below the occupancy are read
module lru_page_replacement #(
  parameter int unsigned WAYS      = 128,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lpr_stream_if.sink   req_i,
  lpr_stream_if.source rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lpr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lpr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  `include "lru_page_replacement_defines.svh"

  logic [lpr_pkg::CFG_W-1:0] ways_q;
  lpr_pkg::cmd_t             cmd;
  logic                      cfg_wr;

  // register write at the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == lpr_pkg::REG_SEL_WAYS_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= lpr_pkg::WAYS_IN_USE_RESET;
    end else if (cfg_wr) begin
      ways_q <= pwdata[lpr_pkg::CFG_W-1:0];
    end
  end

  // register readback
  assign prdata = (paddr[2] == lpr_pkg::REG_SEL_WAYS_IN_USE) ?
                  {{(lpr_pkg::APB_DATA_W - lpr_pkg::CFG_W){1'b0}}, ways_q} : '0;

  // controller
  lpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // datapath
  lpr_datapath #(
    .WAYS      (WAYS),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_i         (req_i.payload),
    .ways_in_use_i (ways_q),
    .rsp_o         (rsp_o.payload)
  );

  // checks
  `LPR_ASSERT_NEXT(a_accept_starts_compare, req_i.valid && req_i.ready, cmd.cmp,
                   "accepted request did not move to compare")
  `LPR_ASSERT_IMPL(a_single_command, 1'b1, $onehot0(cmd), "more than one datapath command")
  `LPR_ASSERT_NEXT(a_update_fills_output, cmd.upd, rsp_o.valid,
                   "update did not present a response")
  `LPR_ASSERT_IMPL(a_hit_counted, rsp_o.valid && rsp_o.payload.hit,
                   rsp_o.payload.hit_count != 32'd0, "hit reported with zero hit count")
  `LPR_ASSERT_IMPL(a_hit_no_evict, rsp_o.valid && rsp_o.payload.hit,
                   !rsp_o.payload.evicted_valid, "hit reported with an eviction")

endmodule

/* sv/lpr_ctrl.sv */
// sequencing state machine of the lru page replacement block
module lpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output lpr_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ENC,
    ST_SEL,
    ST_UPD
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   out_free;

  // the result register can take a new response
  assign out_free = !rsp_valid_q || rsp_ready_i;

  // command decode
  always_comb begin
    cmd_o     = '0;
    cmd_o.cap = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.cmp = (state_q == ST_CMP);
    cmd_o.enc = (state_q == ST_ENC);
    cmd_o.sel = (state_q == ST_SEL);
    cmd_o.upd = (state_q == ST_UPD) && out_free;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  // state and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      // response valid: set on update, cleared once taken
      if ((state_q == ST_UPD) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: state_q <= ST_ENC;
        ST_ENC: state_q <= ST_SEL;
        ST_SEL: state_q <= ST_UPD;
        ST_UPD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sv/lpr_datapath.sv */
// recency stack, parallel compare, hit encoder and counters
module lpr_datapath #(
  parameter int unsigned WAYS      = 128,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpr_pkg::cmd_t              cmd_i,
  input  lpr_pkg::req_t              req_i,
  input  logic [lpr_pkg::CFG_W-1:0]  ways_in_use_i,
  output lpr_pkg::rsp_t              rsp_o
);

  localparam int unsigned OCC_W  = $clog2(WAYS + 1);
  localparam int unsigned IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned NG     = (WAYS + lpr_pkg::GRP_SIZE - 1) / lpr_pkg::GRP_SIZE;
  localparam int unsigned MATCH_W = NG * lpr_pkg::GRP_SIZE;

  // stack and counters
  logic [PAGE_BITS-1:0] pages_q [WAYS];
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic [lpr_pkg::COUNT_W-1:0] hits_q, hits_d;

  // request and stage registers
  logic                 action_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [MATCH_W-1:0]   match_q, match_d;
  logic [PAGE_BITS-1:0] evict_pg_q;
  logic [OCC_W-1:0]     lim_q, lim_d;
  logic [NG-1:0]        grp_hit_q, grp_hit_d;
  logic [lpr_pkg::GRP_IDX_W-1:0] grp_idx_q [NG];
  logic [lpr_pkg::GRP_IDX_W-1:0] grp_idx_d [NG];
  logic                 hit_q, hit_d;
  logic                 evict_q, evict_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [IDX_W-1:0]     top_q, top_d;
  lpr_pkg::rsp_t        rsp_q, rsp_d;

  logic [31:0]          page_ext;
  logic [OCC_W-1:0]     last_full;
  logic [IDX_W-1:0]     last_idx;
  logic [31:0]          pos_ext;
  logic [31:0]          evict_ext;

  assign page_ext  = {16'b0, req_i.page};
  assign last_full = occ_q - OCC_W'(1);
  assign last_idx  = last_full[IDX_W-1:0];

  // compare stage: match vector over valid entries, limit clamp
  always_comb begin
    match_d = '0;
    for (int k = 0; k < WAYS; k++) begin
      match_d[k] = (32'(k) < 32'(occ_q)) && (pages_q[k] == page_q);
    end
    if (ways_in_use_i == '0) begin
      lim_d = OCC_W'(1);
    end else if (32'(ways_in_use_i) > 32'(WAYS)) begin
      lim_d = OCC_W'(WAYS);
    end else begin
      lim_d = OCC_W'(ways_in_use_i);
    end
  end

  // encode stage: first hit within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_d[g] = |match_q[g*lpr_pkg::GRP_SIZE +: lpr_pkg::GRP_SIZE];
      grp_idx_d[g] = '0;
      for (int i = lpr_pkg::GRP_SIZE - 1; i >= 0; i--) begin
        if (match_q[g*lpr_pkg::GRP_SIZE + i]) begin
          grp_idx_d[g] = lpr_pkg::GRP_IDX_W'(i);
        end
      end
    end
  end

  // select stage: first hit group, shift depth and eviction
  always_comb begin
    hit_d   = 1'b0;
    pos_ext = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        hit_d   = 1'b1;
        pos_ext = 32'(g) * 32'(lpr_pkg::GRP_SIZE) + 32'(grp_idx_q[g]);
      end
    end
    pos_d   = pos_ext[IDX_W-1:0];
    evict_d = 1'b0;
    if (hit_d) begin
      top_d = pos_d;
    end else if (occ_q < lim_q) begin
      top_d = occ_q[IDX_W-1:0];
    end else begin
      top_d   = last_idx;
      evict_d = 1'b1;
    end
  end

  // update stage: counters and response
  always_comb begin
    occ_d     = occ_q;
    hits_d    = hits_q;
    evict_ext = 32'(evict_pg_q);
    rsp_d     = '0;
    if (action_q == lpr_pkg::ACT_CLEAR) begin
      occ_d  = '0;
      hits_d = '0;
    end else begin
      if (hit_q) begin
        if (hits_q != lpr_pkg::HIT_COUNT_MAX) begin
          hits_d = hits_q + 32'd1;
        end
      end else if (!evict_q) begin
        occ_d = occ_q + OCC_W'(1);
      end
      rsp_d.hit           = hit_q;
      rsp_d.hit_position  = hit_q ? lpr_pkg::POS_W'(pos_q) : '0;
      rsp_d.evicted_valid = evict_q;
      rsp_d.evicted_page  = evict_q ? evict_ext[lpr_pkg::PAGE_W-1:0] : '0;
    end
    rsp_d.hit_count = hits_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      hits_q <= '0;
    end else if (cmd_i.upd) begin
      occ_q  <= occ_d;
      hits_q <= hits_d;
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      action_q <= req_i.action;
      page_q   <= page_ext[PAGE_BITS-1:0];
    end
    if (cmd_i.cmp) begin
      match_q    <= match_d;
      lim_q      <= lim_d;
      evict_pg_q <= pages_q[last_idx];
    end
    if (cmd_i.enc) begin
      grp_hit_q <= grp_hit_d;
      grp_idx_q <= grp_idx_d;
    end
    if (cmd_i.sel) begin
      hit_q   <= hit_d;
      pos_q   <= pos_d;
      top_q   <= top_d;
      evict_q <= evict_d;
    end
    if (cmd_i.upd) begin
      rsp_q <= rsp_d;
    end
  end

  // recency stack shift, new page enters at the front
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && (action_q == lpr_pkg::ACT_REFERENCE)) begin
      pages_q[0] <= page_q;
      for (int k = 1; k < WAYS; k++) begin
        if (32'(k) <= 32'(top_q)) begin
          pages_q[k] <= pages_q[k-1];
        end
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

/* tb/sv/lru_page_replacement_test.sv */
// self-checking testbench of the lru page replacement block

// recency stack predictor and the queue of responses it expects
class recency_stack_model;
  localparam int unsigned STACK_DEPTH = 128;

  logic [lpr_pkg::PAGE_W-1:0]  page_at [STACK_DEPTH];
  bit                          held [STACK_DEPTH];
  int unsigned                 occupancy;
  logic [lpr_pkg::COUNT_W-1:0] hits;
  logic [lpr_pkg::CFG_W-1:0]   ways_reg;
  lpr_pkg::rsp_t               awaited_rsp [$];
  int unsigned                 errors;

  function new();
    empty_stack();
    ways_reg = lpr_pkg::WAYS_IN_USE_RESET;
    errors   = 0;
  endfunction

  function void empty_stack();
    foreach (held[k]) held[k] = 1'b0;
    occupancy = 0;
    hits      = '0;
  endfunction

  function void set_ways(logic [lpr_pkg::CFG_W-1:0] value);
    ways_reg = value;
  endfunction

  function int unsigned outstanding();
    return awaited_rsp.size();
  endfunction

  // shift positions 0..top-1 down by one and put the page in front
  function void push_front(int unsigned top, logic [lpr_pkg::PAGE_W-1:0] pg);
    for (int k = top; k > 0; k--) begin
      page_at[k] = page_at[k-1];
      held[k]    = held[k-1];
    end
    page_at[0] = pg;
    held[0]    = 1'b1;
  endfunction

  // work out the response of one accepted request
  function void note_request(lpr_pkg::req_t r);
    lpr_pkg::rsp_t exp;
    int            found;
    int unsigned   limit;
    exp   = '0;
    found = -1;
    limit = (ways_reg == 0) ? 1 : (ways_reg > STACK_DEPTH) ? STACK_DEPTH : ways_reg;
    if (r.action == lpr_pkg::ACT_CLEAR) begin
      empty_stack();
    end else begin
      for (int j = 0; j < occupancy; j++) begin
        if (held[j] && page_at[j] == r.page) begin
          found = j;
          break;
        end
      end
      if (found >= 0) begin
        exp.hit          = 1'b1;
        exp.hit_position = lpr_pkg::POS_W'(found);
        push_front(found, r.page);
        if (hits != lpr_pkg::HIT_COUNT_MAX) hits++;
      end else if (occupancy < limit) begin
        push_front(occupancy, r.page);
        occupancy++;
      end else begin
        // full: the last entry drops out
        exp.evicted_valid = 1'b1;
        exp.evicted_page  = page_at[occupancy-1];
        push_front(occupancy - 1, r.page);
      end
    end
    exp.hit_count = hits;
    awaited_rsp.push_back(exp);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      errors++;
    end
  endfunction

  // compare a response with the oldest expectation
  function void check_response(lpr_pkg::rsp_t got);
    lpr_pkg::rsp_t exp;
    if (awaited_rsp.size() == 0) begin
      $error("response with no request outstanding");
      errors++;
    end else begin
      exp = awaited_rsp.pop_front();
      compare_field("hit", exp.hit, got.hit);
      compare_field("hit_position", exp.hit_position, got.hit_position);
      compare_field("evicted_valid", exp.evicted_valid, got.evicted_valid);
      compare_field("evicted_page", exp.evicted_page, got.evicted_page);
      compare_field("hit_count", exp.hit_count, got.hit_count);
    end
  endfunction
endclass

module lru_page_replacement_test;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT = 28;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lpr_pkg::APB_ADDR_W-1:0] paddr;
  logic [lpr_pkg::APB_DATA_W-1:0] pwdata;
  logic [lpr_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  lpr_stream_if #(.T(lpr_pkg::req_t)) req_if ();
  lpr_stream_if #(.T(lpr_pkg::rsp_t)) rsp_if ();

  recency_stack_model sb;
  bit                 calm;
  int unsigned        quiet_cycles;

  lru_page_replacement u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // response side: check accepted responses, stall at random unless calm is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles where neither side moves
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** lru_page_replacement: FAILED **");
    $finish;
  end

  // send one request, with random idle cycles ahead of it unless calm is set
  task automatic send_request(input logic action,
                              input logic [lpr_pkg::PAGE_W-1:0] page);
    lpr_pkg::req_t r;
    r.action = action;
    r.page   = page;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  // stop sending, wait for every expected response, then wait SETTLE_CYCLES more
  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write of ways_in_use, then read it back
  task automatic program_ways(input logic [lpr_pkg::CFG_W-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lpr_pkg::REG_SEL_WAYS_IN_USE, 2'b00};
    pwdata  <= lpr_pkg::APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== lpr_pkg::APB_DATA_W'(value)) begin
      $error("ways_in_use readback: expected %0d, got %0d", value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_ways(value);
  endtask

  // random references drawn mostly from a pool a bit larger than the limit
  task automatic run_phase(input logic [lpr_pkg::CFG_W-1:0] ways,
                           input int unsigned items, input bit pause_mid);
    int unsigned                limit;
    int unsigned                pool;
    int unsigned                pick;
    logic [lpr_pkg::PAGE_W-1:0] base;
    logic [lpr_pkg::PAGE_W-1:0] page;
    program_ways(ways);
    limit = (ways == 0) ? 1 : (ways > 128) ? 128 : ways;
    pool  = limit + limit / 2 + 2;
    base  = lpr_pkg::PAGE_W'($urandom);
    for (int i = 0; i < items; i++) begin
      if (pause_mid && i == items / 2) settle();
      pick = $urandom_range(0, 99);
      page = base + lpr_pkg::PAGE_W'($urandom_range(0, pool - 1));
      if (pick < 2)
        send_request(lpr_pkg::ACT_CLEAR, lpr_pkg::PAGE_W'($urandom));
      else if (pick < 12)
        send_request(lpr_pkg::ACT_REFERENCE, lpr_pkg::PAGE_W'($urandom));
      else
        send_request(lpr_pkg::ACT_REFERENCE, page);
    end
  endtask

  // stimulus
  initial begin
    logic [lpr_pkg::PAGE_W-1:0] base;
    sb             = new();
    calm           = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // page extremes, hits at front and second place, clear
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0000);
    send_request(lpr_pkg::ACT_REFERENCE, 16'hffff);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0000);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0000);
    send_request(lpr_pkg::ACT_REFERENCE, 16'hffff);
    send_request(lpr_pkg::ACT_CLEAR, 16'haaaa);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0000);
    send_request(lpr_pkg::ACT_CLEAR, 16'h5555);

    // single way: once the one entry is held, every miss evicts
    program_ways(8'd1);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h1234);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h4321);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h4321);

    // zero limit behaves as one
    program_ways(8'd0);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h1234);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h1234);

    // limit lowered below occupancy: old entries still hit, misses evict the last
    program_ways(8'd4);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0001);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0002);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0003);
    program_ways(8'd2);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h1234);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0009);
    send_request(lpr_pkg::ACT_REFERENCE, 16'h0003);
    send_request(lpr_pkg::ACT_CLEAR, 16'h0000);

    // random phases over several limits, one without idling, one with a pause
    run_phase(8'd128, 70, 1'b0);
    run_phase(8'd1, 50, 1'b0);
    calm = 1'b1;
    run_phase(8'd3, 60, 1'b0);
    calm = 1'b0;
    run_phase(8'd255, 70, 1'b1);
    run_phase(8'd0, 40, 1'b0);
    run_phase(8'd16, 70, 1'b0);
    run_phase(8'd5, 60, 1'b0);
    run_phase(8'd64, 70, 1'b0);
    run_phase(8'd2, 50, 1'b0);
    run_phase(8'd8, 60, 1'b0);

    // fill all ways, hit the deepest entry, then evict from a full stack
    program_ways(8'd128);
    base = lpr_pkg::PAGE_W'($urandom);
    send_request(lpr_pkg::ACT_CLEAR, lpr_pkg::PAGE_W'($urandom));
    for (int i = 0; i < 128; i++)
      send_request(lpr_pkg::ACT_REFERENCE, base + lpr_pkg::PAGE_W'(i));
    send_request(lpr_pkg::ACT_REFERENCE, base);
    send_request(lpr_pkg::ACT_REFERENCE, base + lpr_pkg::PAGE_W'(200));
    send_request(lpr_pkg::ACT_REFERENCE, base + lpr_pkg::PAGE_W'(2));

    settle();
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("** lru_page_replacement: PASSED **");
    else
      $display("** lru_page_replacement: FAILED **");
    $finish;
  end
endmodule
